/* sv/lkpm_pkg.sv */
// Shared constants and character functions for the keyword prefix matcher.
`default_nettype none
package lkpm_pkg;
    localparam int MaxKeywords = 256;
    localparam int MaxKeywordLen = 32;
    localparam int IdxW = $clog2(MaxKeywords);
    localparam int CntW = IdxW + 1;
    localparam int PosW = $clog2(MaxKeywordLen);
    localparam int LenW = 6;
    localparam int TextAw = IdxW + PosW;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_MATCH = 2'd2;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
    endfunction
endpackage
`default_nettype wire

/* sv/lkpm_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lkpm_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]              rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* sv/longest_keyword_prefix_matcher.sv */
// Top level: keyword table, binary narrowing sequencer and candidate check.
//
//  channel   signals                          transfer
//  command   start, kind, char_code, last     start && !busy
//  result    result_valid, match_length, found one cycle, no stall
//
// Clear and load leave busy low. A match character holds busy while it probes the
// shared table read ports in a binary search for the lower and then the upper
// bound of its key range, and while it closes the two searches. Resolution pops
// candidates, compares their characters and then emits the result.
// Table reads go through the registered read ports of the text and length RAMs.
// Reset is asynchronous and needs no clearing pass. The receiver cannot stall results.
`default_nettype none
module longest_keyword_prefix_matcher
    import lkpm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  char_code,
    input  wire logic        last,
    output logic             result_valid,
    output logic [5:0]       match_length,
    output logic             found
);
    typedef enum logic [3:0] {
        S_IDLE, S_LO, S_LO_W, S_LO_R, S_HI, S_HI_W, S_HI_R, S_DONE_N,
        S_RES, S_RL_W, S_RL_R, S_RC, S_RC_W, S_RC_R
    } state_t;

    state_t state_reg;
    logic [CntW-1:0] kcount_reg, first_reg, end_reg, lo_reg, cnt_reg, step_reg;
    logic [LenW-1:0] lpos_reg, tpos_reg;
    logic pending_reg, done_reg, last_reg;
    logic [7:0] t_reg, c_reg;
    logic [LenW-1:0] sdepth_reg, valid_reg, clen_reg;
    logic [LenW-1:0] ci_reg;
    logic [IdxW-1:0] cidx_reg;

    logic [MaxKeywordLen-1:0][7:0] tbuf_reg;
    logic [MaxKeywordLen-1:0][IdxW-1:0] stack_reg;

    logic txt_we, len_we;
    logic [TextAw-1:0] txt_waddr, txt_raddr;
    logic [7:0] txt_rdata;
    logic [IdxW-1:0] len_waddr, len_raddr;
    logic [LenW-1:0] len_wdata, len_rdata;

    lkpm_ram #(.Width(8), .Depth(MaxKeywords * MaxKeywordLen)) u_text (
        .clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(char_code),
        .raddr(txt_raddr), .rdata(txt_rdata)
    );
    lkpm_ram #(.Width(LenW), .Depth(MaxKeywords)) u_len (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rdata)
    );

    logic accept;
    assign accept = start && !busy;
    assign busy = (state_reg != S_IDLE);

    logic load_ok;
    assign load_ok = accept && kind == KIND_LOAD && kcount_reg < CntW'(MaxKeywords);
    assign txt_we = load_ok && lpos_reg < LenW'(MaxKeywordLen);
    assign txt_waddr = {kcount_reg[IdxW-1:0], lpos_reg[PosW-1:0]};
    assign len_we = load_ok && last;
    assign len_waddr = kcount_reg[IdxW-1:0];
    assign len_wdata = (lpos_reg < LenW'(MaxKeywordLen)) ? lpos_reg + 1'b1 : lpos_reg;

    // probe index: lower/upper search uses lo+step, candidate check uses cidx
    logic [CntW-1:0] probe;
    assign probe = lo_reg + step_reg;
    logic in_res;
    assign in_res = (state_reg == S_RL_W) || (state_reg == S_RL_R) ||
                    (state_reg == S_RC) || (state_reg == S_RC_W) ||
                    (state_reg == S_RC_R) || (state_reg == S_RES);
    assign len_raddr = in_res ? cidx_reg : probe[IdxW-1:0];
    assign txt_raddr = in_res ? {cidx_reg, ci_reg[PosW-1:0]}
                              : {probe[IdxW-1:0], tpos_reg[PosW-1:0]};

    // key of probed entry at text position
    logic [7:0] key;
    assign key = (tpos_reg < len_rdata) ? to_lower(txt_rdata) : 8'd0;
    logic [7:0] ckey;
    assign ckey = (ci_reg < len_rdata) ? to_lower(txt_rdata) : 8'd0;

    logic [CntW-1:0] half;
    assign half = cnt_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kcount_reg <= '0;
            lpos_reg <= '0;
            first_reg <= '0;
            end_reg <= '0;
            tpos_reg <= '0;
            pending_reg <= 1'b0;
            sdepth_reg <= '0;
            done_reg <= 1'b0;
            result_valid <= 1'b0;
            match_length <= '0;
            found <= 1'b0;
            lo_reg <= '0;
            cnt_reg <= '0;
            step_reg <= '0;
            last_reg <= 1'b0;
            t_reg <= '0;
            c_reg <= '0;
            valid_reg <= '0;
            clen_reg <= '0;
            ci_reg <= '0;
            cidx_reg <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (accept)
                    begin
                        last_reg <= last;
                        c_reg <= char_code;
                        t_reg <= to_lower(char_code);
                        if (kind == KIND_CLEAR || kind == KIND_LOAD)
                        begin
                            if (kind == KIND_CLEAR)
                            begin
                                kcount_reg <= '0;
                                lpos_reg <= '0;
                                end_reg <= '0;
                            end
                            else
                            begin
                                if (load_ok && lpos_reg < LenW'(MaxKeywordLen))
                                begin
                                    lpos_reg <= lpos_reg + 1'b1;
                                end
                                if (last)
                                begin
                                    lpos_reg <= '0;
                                end
                                if (load_ok && last)
                                begin
                                    kcount_reg <= kcount_reg + 1'b1;
                                    end_reg <= kcount_reg + 1'b1;
                                end
                                else
                                begin
                                    end_reg <= kcount_reg;
                                end
                            end
                            first_reg <= '0;
                            tpos_reg <= '0;
                            pending_reg <= 1'b0;
                            sdepth_reg <= '0;
                            done_reg <= 1'b0;
                        end
                        else if (kind == KIND_MATCH)
                        begin
                            if (done_reg)
                            begin
                                if (last)
                                begin
                                    first_reg <= '0;
                                    end_reg <= kcount_reg;
                                    tpos_reg <= '0;
                                    pending_reg <= 1'b0;
                                    sdepth_reg <= '0;
                                    done_reg <= 1'b0;
                                end
                            end
                            else
                            begin
                                if (pending_reg && !is_word_char(char_code) &&
                                    sdepth_reg < LenW'(MaxKeywordLen))
                                begin
                                    stack_reg[sdepth_reg[PosW-1:0]] <= first_reg[IdxW-1:0];
                                    sdepth_reg <= sdepth_reg + 1'b1;
                                end
                                pending_reg <= 1'b0;
                                if (char_code == 8'd0 || tpos_reg >= LenW'(MaxKeywordLen))
                                begin
                                    state_reg <= S_DONE_N;
                                end
                                else
                                begin
                                    lo_reg <= first_reg;
                                    cnt_reg <= (end_reg > first_reg) ? end_reg - first_reg : '0;
                                    state_reg <= S_LO;
                                end
                            end
                        end
                    end
                end
                S_LO:
                begin
                    if (cnt_reg == '0)
                    begin
                        first_reg <= lo_reg;
                        cnt_reg <= (end_reg > lo_reg) ? end_reg - lo_reg : '0;
                        state_reg <= S_HI;
                    end
                    else
                    begin
                        step_reg <= half;
                        state_reg <= S_LO_W;
                    end
                end
                S_LO_W: state_reg <= S_LO_R;
                S_LO_R:
                begin
                    if (key < t_reg)
                    begin
                        lo_reg <= probe + 1'b1;
                        cnt_reg <= cnt_reg - step_reg - 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= step_reg;
                    end
                    step_reg <= '0;
                    state_reg <= S_LO;
                end
                S_HI:
                begin
                    if (cnt_reg == '0)
                    begin
                        end_reg <= lo_reg;
                        if (first_reg == lo_reg)
                        begin
                            state_reg <= S_DONE_N;
                        end
                        else
                        begin
                            tbuf_reg[tpos_reg[PosW-1:0]] <= c_reg;
                            tpos_reg <= tpos_reg + 1'b1;
                            pending_reg <= 1'b1;
                            if (last_reg)
                            begin
                                if (sdepth_reg < LenW'(MaxKeywordLen))
                                begin
                                    stack_reg[sdepth_reg[PosW-1:0]] <= first_reg[IdxW-1:0];
                                    sdepth_reg <= sdepth_reg + 1'b1;
                                end
                                valid_reg <= tpos_reg + 1'b1;
                                state_reg <= S_RES;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        step_reg <= half;
                        state_reg <= S_HI_W;
                    end
                end
                S_HI_W: state_reg <= S_HI_R;
                S_HI_R:
                begin
                    if (!(t_reg < key))
                    begin
                        lo_reg <= probe + 1'b1;
                        cnt_reg <= cnt_reg - step_reg - 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= step_reg;
                    end
                    step_reg <= '0;
                    state_reg <= S_HI;
                end
                S_DONE_N:
                begin
                    // range empty or text ended: buffer char if room, then resolve
                    if (tpos_reg < LenW'(MaxKeywordLen))
                    begin
                        tbuf_reg[tpos_reg[PosW-1:0]] <= c_reg;
                        valid_reg <= tpos_reg + 1'b1;
                    end
                    else
                    begin
                        valid_reg <= tpos_reg;
                    end
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (sdepth_reg == '0)
                    begin
                        result_valid <= 1'b1;
                        match_length <= tpos_reg;
                        found <= 1'b0;
                        state_reg <= S_IDLE;
                        if (last_reg)
                        begin
                            first_reg <= '0;
                            end_reg <= kcount_reg;
                            tpos_reg <= '0;
                            pending_reg <= 1'b0;
                            done_reg <= 1'b0;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        cidx_reg <= stack_reg[sdepth_reg[PosW-1:0] - 1'b1];
                        sdepth_reg <= sdepth_reg - 1'b1;
                        ci_reg <= '0;
                        state_reg <= S_RL_W;
                    end
                end
                S_RL_W: state_reg <= S_RL_R;
                S_RL_R:
                begin
                    clen_reg <= len_rdata;
                    if (len_rdata > valid_reg || len_rdata > LenW'(MaxKeywordLen))
                    begin
                        state_reg <= S_RES;
                    end
                    else
                    begin
                        state_reg <= S_RC;
                    end
                end
                S_RC:
                begin
                    if (ci_reg == clen_reg)
                    begin
                        result_valid <= 1'b1;
                        match_length <= clen_reg;
                        found <= 1'b1;
                        sdepth_reg <= '0;
                        state_reg <= S_IDLE;
                        if (last_reg)
                        begin
                            first_reg <= '0;
                            end_reg <= kcount_reg;
                            tpos_reg <= '0;
                            pending_reg <= 1'b0;
                            done_reg <= 1'b0;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_RC_W;
                    end
                end
                S_RC_W: state_reg <= S_RC_R;
                S_RC_R:
                begin
                    if (to_lower(tbuf_reg[ci_reg[PosW-1:0]]) != ckey)
                    begin
                        state_reg <= S_RES;
                    end
                    else
                    begin
                        ci_reg <= ci_reg + 1'b1;
                        state_reg <= S_RC;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* tb/longest_keyword_prefix_matcher_tb.sv */
// Self-checking testbench for the longest keyword prefix matcher.
`default_nettype none
module longest_keyword_prefix_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lkpm_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int ItemTarget = 1350;
    localparam int TailCycles = 5000;

    typedef struct packed {
        logic [5:0] length;
        logic       hit;
    } match_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] kind = KIND_CLEAR;
    logic [7:0] char_code = 8'd0;
    logic       last = 1'b0;
    logic       busy;
    logic       result_valid;
    logic [5:0] match_length;
    logic       found;

    match_result_t expected_matches[$];
    int mismatch_count = 0;
    int idle_pct = 0;
    int accepted_items = 0;

    logic [7:0] kw_text[MaxKeywords*MaxKeywordLen];
    int kw_len[MaxKeywords];
    int kw_count, load_pos, range_first, range_end, text_pos;
    int pending_push, stack_depth, search_done;
    logic [7:0] text_buf[MaxKeywordLen];
    int cand_stack[MaxKeywordLen];

    string table_words[16];
    int table_size;

    longest_keyword_prefix_matcher uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .char_code(char_code), .last(last),
        .result_valid(result_valid), .match_length(match_length), .found(found)
    );

    always #2 clk = ~clk;

    function automatic int fold_case(input int c);
        return (c >= "A" && c <= "Z") ? c + 32 : c;
    endfunction

    function automatic int key_at(input int idx, input int pos);
        if (idx >= MaxKeywords || pos >= MaxKeywordLen || pos >= kw_len[idx])
        begin
            return 0;
        end
        return fold_case(kw_text[idx*MaxKeywordLen+pos]);
    endfunction

    task automatic restart_text();
        range_first = 0;
        range_end = kw_count;
        text_pos = 0;
        pending_push = 0;
        stack_depth = 0;
        search_done = 0;
    endtask

    task automatic push_candidate();
        if (stack_depth < MaxKeywordLen)
        begin
            cand_stack[stack_depth] = range_first;
            stack_depth++;
        end
    endtask

    function automatic int narrow_range(input int t);
        int lo, hi, cnt, step, it;
        lo = range_first;
        cnt = range_end > lo ? range_end - lo : 0;
        while (cnt > 0)
        begin
            step = cnt / 2;
            it = lo + step;
            if (key_at(it, text_pos) < t)
            begin
                lo = it + 1;
                cnt -= step + 1;
            end
            else
                cnt = step;
        end
        hi = lo;
        cnt = range_end > lo ? range_end - lo : 0;
        while (cnt > 0)
        begin
            step = cnt / 2;
            it = hi + step;
            if (!(t < key_at(it, text_pos)))
            begin
                hi = it + 1;
                cnt -= step + 1;
            end
            else
                cnt = step;
        end
        range_first = lo;
        range_end = hi;
        return lo != hi;
    endfunction

    task automatic resolve_match(input int valid);
        int idx, len;
        bit ok;
        match_result_t r;
        for (int d = stack_depth; d > 0; d--)
        begin
            idx = cand_stack[d-1];
            if (idx >= MaxKeywords)
                continue;
            len = kw_len[idx];
            ok = len <= valid && len <= MaxKeywordLen;
            for (int i = 0; ok && i < len; i++)
                if (fold_case(text_buf[i]) != key_at(idx, i))
                    ok = 0;
            if (ok)
            begin
                r.length = len[5:0];
                r.hit = 1'b1;
                expected_matches.insert(expected_matches.size(), r);
                return;
            end
        end
        r.length = text_pos[5:0];
        r.hit = 1'b0;
        expected_matches.insert(expected_matches.size(), r);
    endtask

    function automatic bit is_word(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "_";
    endfunction

    task automatic predict_match(input logic [1:0] k, input logic [7:0] c, input logic l);
        int valid;
        if (k == KIND_CLEAR)
        begin
            kw_count = 0;
            load_pos = 0;
            restart_text();
        end
        else if (k == KIND_LOAD)
        begin
            if (kw_count < MaxKeywords)
            begin
                if (load_pos < MaxKeywordLen)
                begin
                    kw_text[kw_count*MaxKeywordLen+load_pos] = c;
                    load_pos++;
                end
                if (l)
                begin
                    kw_len[kw_count] = load_pos;
                    kw_count++;
                end
            end
            if (l)
                load_pos = 0;
            restart_text();
        end
        else if (k == KIND_MATCH)
        begin
            if (search_done)
            begin
                if (l)
                    restart_text();
            end
            else
            begin
                if (pending_push && !is_word(c))
                    push_candidate();
                pending_push = 0;
                if (c == 0 || text_pos >= MaxKeywordLen || !narrow_range(fold_case(c)))
                begin
                    valid = text_pos;
                    if (text_pos < MaxKeywordLen)
                    begin
                        text_buf[text_pos] = c;
                        valid = text_pos + 1;
                    end
                    resolve_match(valid);
                    if (l)
                        restart_text();
                    else
                        search_done = 1;
                end
                else
                begin
                    text_buf[text_pos] = c;
                    text_pos++;
                    pending_push = 1;
                    if (l)
                    begin
                        push_candidate();
                        resolve_match(text_pos);
                        restart_text();
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        match_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (expected_matches.size() == 0)
                report_mismatch($sformatf("unexpected result len=%0d found=%0b",
                                          match_length, found));
            else
            begin
                exp_r = expected_matches.pop_front();
                if (match_length !== exp_r.length)
                    report_mismatch($sformatf("match_length %0d, want %0d",
                                              match_length, exp_r.length));
                if (found !== exp_r.hit)
                    report_mismatch($sformatf("found %0b, want %0b", found, exp_r.hit));
            end
        end
    end

    task automatic send_item(input logic [1:0] k, input logic [7:0] c, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        char_code <= c;
        last <= l;
        do
            @(posedge clk);
        while (busy);
        predict_match(k, c, l);
        if (k != KIND_NONE)
            accepted_items++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
    endtask

    task automatic load_word(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(KIND_LOAD, s[i], i == s.len() - 1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            if ($urandom_range(59) == 0)
                send_item(KIND_NONE, 8'($urandom), 1'($urandom));
            send_item(KIND_MATCH, s[i], i == s.len() - 1);
        end
    endtask

    function automatic string add_char(input string s, input logic [7:0] c);
        string r;
        r = {s, " "};
        r.putc(r.len() - 1, c);
        return r;
    endfunction

    function automatic string random_word(input int max_len);
        string pool, s;
        pool = "abc_1";
        s = "";
        repeat ($urandom_range(1, max_len))
            s = add_char(s, pool[$urandom_range(pool.len() - 1)]);
        return s;
    endfunction

    function automatic string make_text();
        string w, t, seps;
        int n;
        seps = " (.+;";
        t = "";
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                t = add_char(t, 8'($urandom_range(255)));
            return t;
        end
        w = table_words[$urandom_range(table_size - 1)];
        n = ($urandom_range(4) == 0) ? $urandom_range(1, w.len()) : w.len();
        for (int i = 0; i < n; i++)
            t = add_char(t, (w[i] >= "a" && w[i] <= "z" && $urandom_range(1))
                            ? w[i] - 8'd32 : w[i]);
        case ($urandom_range(5))
            1: t = {t, random_word(4)};
            2: t = {add_char(t, seps[$urandom_range(seps.len() - 1)]), random_word(3)};
            3: t = {t, table_words[$urandom_range(table_size - 1)]};
            4: repeat ($urandom_range(1, 3)) t = add_char(t, 8'($urandom_range(255)));
            5: repeat ($urandom_range(30, 36)) t = add_char(t, "a");
            default: ;
        endcase
        return t;
    endfunction

    task automatic test_directed();
        send_item(KIND_CLEAR, 8'hFF, 1'b1);
        send_item(KIND_MATCH, "a", 1'b1);
        load_word("if");
        load_word("int");
        load_word("print");
        send_text("IF(");
        send_text("integer");
        send_text("in");
        send_item(KIND_MATCH, 8'h00, 1'b1);
        send_item(KIND_MATCH, 8'h80, 1'b0);
        send_item(KIND_MATCH, "i", 1'b1);
        send_item(KIND_NONE, 8'h7F, 1'b0);
        send_text("pr");
        send_item(KIND_LOAD, "b", 1'b1);
        send_item(KIND_LOAD, "a", 1'b1);
        send_text("a ");
        send_item(KIND_CLEAR, 8'h00, 1'b0);
    endtask

    task automatic test_long_keyword();
        string s;
        s = "";
        repeat (40) s = add_char(s, "a");
        send_item(KIND_CLEAR, 8'h00, 1'b0);
        load_word(s);
        send_text(s);
        send_text(s.substr(0, 31));
    endtask

    task automatic test_table_full();
        send_item(KIND_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < MaxKeywords; i++)
        begin
            send_item(KIND_LOAD, 8'(97 + i / 16), 1'b0);
            send_item(KIND_LOAD, 8'(97 + i % 16), 1'b1);
        end
        load_word("zz");
        send_text("pp");
        send_text("aa ");
        send_text("Zz");
        send_text("dk(");
    endtask

    task automatic run_session();
        string tmp;
        send_item(KIND_CLEAR, 8'($urandom), 1'($urandom));
        table_size = $urandom_range(1, 12);
        for (int i = 0; i < table_size; i++)
            table_words[i] = random_word(6);
        if ($urandom_range(9) != 0)
            for (int i = 0; i < table_size; i++)
                for (int j = 0; j + 1 < table_size - i; j++)
                    if (table_words[j+1] < table_words[j])
                    begin
                        tmp = table_words[j];
                        table_words[j] = table_words[j+1];
                        table_words[j+1] = tmp;
                    end
        for (int i = 0; i < table_size; i++)
            load_word(table_words[i]);
        repeat ($urandom_range(4, 12))
            send_text(make_text());
    endtask

    task automatic test_random(input int pct, input int target);
        idle_pct = pct;
        while (accepted_items < target)
            run_session();
        idle_pct = 0;
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_long_keyword();
        test_table_full();
        wait_drained();
        test_random(0, ItemTarget - 510);
        test_random(74, ItemTarget - 340);
        test_random(0, ItemTarget - 170);
        test_random(26, ItemTarget);
        if (mismatch_count == 0 && expected_matches.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
